[rtl/rv64_subset_decode_execute_assert.svh]
// assertion macros for the rv64 subset decode-execute block
`ifndef RV64_SUBSET_DECODE_EXECUTE_ASSERT_SVH
`define RV64_SUBSET_DECODE_EXECUTE_ASSERT_SVH
`ifndef SYNTHESIS
`define RV64SDE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rv64sde assertion failed");
`define RV64SDE_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rv64sde forbidden condition seen");
`else
`define RV64SDE_ASSERT(lbl, clk, rst_n, prop)
`define RV64SDE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/rv64sde_pkg.sv]
// types and constants shared by the rv64 subset decode-execute block
package rv64sde_pkg;

  localparam int unsigned XLen     = 64;
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegIdxW  = 5;

  localparam logic [RegIdxW-1:0] RegZero = 5'd0;
  localparam logic [RegIdxW-1:0] RegSp   = 5'd2;

  // instruction length field in bits 1:0
  localparam logic [1:0] QuadC0  = 2'b00;
  localparam logic [1:0] QuadC1  = 2'b01;
  localparam logic [1:0] QuadC2  = 2'b10;
  localparam logic [1:0] QuadStd = 2'b11;

  localparam logic [2:0] F3CAddi = 3'b000;
  localparam logic [2:0] F3CLui  = 3'b011;
  localparam logic [2:0] F3CSdsp = 3'b111;
  localparam logic [2:0] F3Addi  = 3'b000;

  localparam logic [6:0] OpcOpImm = 7'b0010011;
  localparam logic [6:0] OpcJal   = 7'b1101111;

  localparam logic [1:0] StContinue = 2'd0;
  localparam logic [1:0] StStop     = 2'd1;
  localparam logic [1:0] StNoDecode = 2'd2;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenC    = 3'd2;
  localparam logic [2:0] LenStd  = 3'd4;

  typedef struct packed {
    logic [31:0]     instruction_word;
    logic [XLen-1:0] pc;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         length;
    logic [XLen-1:0]    next_pc;
    logic               reg_write_valid;
    logic [RegIdxW-1:0] reg_index;
    logic [XLen-1:0]    reg_value;
    logic               store_valid;
    logic [XLen-1:0]    store_address;
    logic [XLen-1:0]    store_data;
  } out_item_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [XLen-1:0]    data;
  } rf_wr_t;

endpackage

[rtl/rv64sde_rf.sv]
// 32 x 64 register file with registered reads, reset valid bits and write forwarding
module rv64sde_rf (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rv64sde_pkg::rf_wr_t                 wr_i,
  input  logic                                rd_en_i,
  input  logic [rv64sde_pkg::RegIdxW-1:0]     rd_addr_i,
  output logic [rv64sde_pkg::XLen-1:0]        rd_data_o,
  output logic [rv64sde_pkg::XLen-1:0]        sp_data_o
);

  logic [rv64sde_pkg::XLen-1:0]     mem_q [rv64sde_pkg::RegCount];
  logic [rv64sde_pkg::RegCount-1:0] vld_q;
  logic [rv64sde_pkg::XLen-1:0]     rd_data_q;
  logic [rv64sde_pkg::XLen-1:0]     sp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  // a write landing in the same cycle is forwarded into the read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.idx == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else if (vld_q[rd_addr_i]) begin
        rd_data_q <= mem_q[rd_addr_i];
      end else begin
        rd_data_q <= '0;
      end
      if (wr_i.en && (wr_i.idx == rv64sde_pkg::RegSp)) begin
        sp_data_q <= wr_i.data;
      end else if (vld_q[rv64sde_pkg::RegSp]) begin
        sp_data_q <= mem_q[rv64sde_pkg::RegSp];
      end else begin
        sp_data_q <= '0;
      end
    end
  end

  assign rd_data_o = rd_data_q;
  assign sp_data_o = sp_data_q;

endmodule

[rtl/rv64sde_exec.sv]
// decode and execute of one instruction from its operands
module rv64sde_exec (
  input  rv64sde_pkg::in_item_t          item_i,
  input  logic [rv64sde_pkg::XLen-1:0]   rs_data_i,
  input  logic [rv64sde_pkg::XLen-1:0]   sp_data_i,
  output rv64sde_pkg::out_item_t         res_o,
  output rv64sde_pkg::rf_wr_t            wr_o
);

  logic [31:0]                     w;
  logic [rv64sde_pkg::XLen-1:0]    pc;
  logic [2:0]                      c_f3;
  logic [rv64sde_pkg::RegIdxW-1:0] rd;
  logic [5:0]                      imm6;
  logic [8:0]                      sdsp_off;
  logic [20:0]                     jal_off;
  rv64sde_pkg::out_item_t          res;
  logic                            ok;

  assign w        = item_i.instruction_word;
  assign pc       = item_i.pc;
  assign c_f3     = w[15:13];
  assign rd       = w[11:7];
  assign imm6     = {w[12], w[6:2]};
  assign sdsp_off = {w[9:7], w[12:10], 3'b000};
  assign jal_off  = {w[31], w[19:12], w[20], w[30:21], 1'b0};

  always_comb begin
    res     = '0;
    ok      = 1'b0;
    res.status = rv64sde_pkg::StContinue;
    unique case (w[1:0])
      rv64sde_pkg::QuadStd: begin
        res.length = rv64sde_pkg::LenStd;
        if ((w[6:0] == rv64sde_pkg::OpcOpImm) && (w[14:12] == rv64sde_pkg::F3Addi)
            && (rd != rv64sde_pkg::RegZero)) begin
          ok                  = 1'b1;
          res.reg_write_valid = 1'b1;
          res.reg_index       = rd;
          res.reg_value       = rs_data_i + {{52{w[31]}}, w[31:20]};
          res.next_pc         = pc + 64'd4;
        end else if (w[6:0] == rv64sde_pkg::OpcJal) begin
          ok         = 1'b1;
          res.status = rv64sde_pkg::StStop;
          if (rd != rv64sde_pkg::RegZero) begin
            res.reg_write_valid = 1'b1;
            res.reg_index       = rd;
            res.reg_value       = pc + 64'd4;
          end
          res.next_pc = pc + {{43{jal_off[20]}}, jal_off};
        end
      end
      default: begin
        res.length  = rv64sde_pkg::LenC;
        res.next_pc = pc + 64'd2;
        if ((w[1:0] == rv64sde_pkg::QuadC1) && (c_f3 == rv64sde_pkg::F3CAddi)
            && (rd != rv64sde_pkg::RegZero) && (imm6 != 6'd0)) begin
          ok                  = 1'b1;
          res.reg_write_valid = 1'b1;
          res.reg_index       = rd;
          res.reg_value       = rs_data_i + {{58{imm6[5]}}, imm6};
        end else if ((w[1:0] == rv64sde_pkg::QuadC1) && (c_f3 == rv64sde_pkg::F3CLui)
                     && (rd != rv64sde_pkg::RegZero) && (rd != rv64sde_pkg::RegSp)
                     && (imm6 != 6'd0)) begin
          ok                  = 1'b1;
          res.reg_write_valid = 1'b1;
          res.reg_index       = rd;
          res.reg_value       = {{46{imm6[5]}}, imm6, 12'd0};
        end else if ((w[1:0] == rv64sde_pkg::QuadC2) && (c_f3 == rv64sde_pkg::F3CSdsp)) begin
          ok                = 1'b1;
          res.store_valid   = 1'b1;
          res.store_address = sp_data_i + {55'd0, sdsp_off};
          res.store_data    = rs_data_i;
        end
      end
    endcase
    if (!ok) begin
      res         = '0;
      res.status  = rv64sde_pkg::StNoDecode;
      res.length  = rv64sde_pkg::LenNone;
      res.next_pc = pc;
    end
  end

  assign res_o   = res;
  assign wr_o.en = res.reg_write_valid && (res.reg_index != rv64sde_pkg::RegZero);
  assign wr_o.idx  = res.reg_index;
  assign wr_o.data = res.reg_value;

endmodule

[rtl/rv64_subset_decode_execute.sv]
// top level of the rv64 subset decode-execute block
// Usage:
// - input channel in_valid_i / in_ready_o carries one item: an instruction word
//   (16-bit form when bits 1:0 are not 3) and its pc
// - output channel out_valid_o / out_ready_i carries one result item per
//   input item: status, length, next pc, register write and store
// - the accepting edge reads rs and x2 from the register file into registers;
//   when the result register is free or being taken, the operand stage
//   decodes, adds and writes the register file and the result register
// - one item per cycle sustained while results are taken; a write in flight is
//   forwarded to the next item's read, so dependent instructions run back to back
// - the register file has per-entry valid bits cleared by reset, so all
//   registers read as zero right after reset with no clearing pass
// - when the receiver stalls, the result register holds its item and the
//   operand stage holds one more; in_ready_o drops only when both are full
`include "rv64_subset_decode_execute_assert.svh"

module rv64_subset_decode_execute (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rv64sde_pkg::in_item_t   in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rv64sde_pkg::out_item_t  out_item_o
);

  logic                            in_fire;
  logic                            s1_fire;
  logic                            s1_valid_d, s1_valid_q;
  logic                            out_valid_d, out_valid_q;
  rv64sde_pkg::in_item_t           item_q;
  rv64sde_pkg::out_item_t          out_item_q;
  rv64sde_pkg::out_item_t          exec_res;
  rv64sde_pkg::rf_wr_t             exec_wr;
  rv64sde_pkg::rf_wr_t             rf_wr;
  logic [rv64sde_pkg::RegIdxW-1:0] rd_addr;
  logic [rv64sde_pkg::XLen-1:0]    rs_data;
  logic [rv64sde_pkg::XLen-1:0]    sp_data;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // source operand select: rs1 for standard, rs2 for quadrant 2, rd otherwise
  always_comb begin
    unique case (in_item_i.instruction_word[1:0])
      rv64sde_pkg::QuadStd: rd_addr = in_item_i.instruction_word[19:15];
      rv64sde_pkg::QuadC2:  rd_addr = in_item_i.instruction_word[6:2];
      default:              rd_addr = in_item_i.instruction_word[11:7];
    endcase
  end

  assign rf_wr.en   = exec_wr.en && s1_fire;
  assign rf_wr.idx  = exec_wr.idx;
  assign rf_wr.data = exec_wr.data;

  rv64sde_rf u_rf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rf_wr),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (rs_data),
    .sp_data_o (sp_data)
  );

  rv64sde_exec u_exec (
    .item_i    (item_q),
    .rs_data_i (rs_data),
    .sp_data_i (sp_data),
    .res_o     (exec_res),
    .wr_o      (exec_wr)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (s1_fire) begin
      out_item_q <= exec_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `RV64SDE_NEVER(a_no_x0_write, clk_i, rst_ni, rf_wr.en && (rf_wr.idx == rv64sde_pkg::RegZero))
  `RV64SDE_ASSERT(a_stall_blocks_input, clk_i, rst_ni, (s1_valid_q && !s1_fire) |-> !in_ready_o)
  `RV64SDE_ASSERT(a_exec_to_out, clk_i, rst_ni, s1_fire |=> out_valid_o)
  `RV64SDE_ASSERT(a_write_reported, clk_i, rst_ni,
                  rf_wr.en |=> (out_item_o.reg_write_valid &&
                                (out_item_o.reg_index == $past(rf_wr.idx))))
  `RV64SDE_ASSERT(a_nodecode_clean, clk_i, rst_ni,
                  (out_valid_o && (out_item_o.status == rv64sde_pkg::StNoDecode)) |->
                  (!out_item_o.reg_write_valid && !out_item_o.store_valid &&
                   (out_item_o.length == rv64sde_pkg::LenNone)))

endmodule

[tb/sv/rv64_subset_decode_execute_tb.sv]
// testbench for the rv64 subset decode-execute block: random and directed instructions
`timescale 1ns / 1ps

module rv64_subset_decode_execute_tb;

  localparam int unsigned RandomItems   = 1200;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 8;

  // architectural mirror of the block: register file and expected result items
  class exec_checker;
    logic [rv64sde_pkg::XLen-1:0] xregs[rv64sde_pkg::RegCount];
    rv64sde_pkg::out_item_t       expected_results[$];
    int unsigned                  errors;
    int unsigned                  n_checked;
    int unsigned                  n_writes;
    int unsigned                  n_stores;
    int unsigned                  n_jumps;
    int unsigned                  n_nodecode;

    function new();
      foreach (xregs[i]) xregs[i] = '0;
      errors     = 0;
      n_checked  = 0;
      n_writes   = 0;
      n_stores   = 0;
      n_jumps    = 0;
      n_nodecode = 0;
    endfunction

    // executes one instruction on the mirror and returns its result item
    function rv64sde_pkg::out_item_t execute_instr(rv64sde_pkg::in_item_t x);
      logic [31:0]                     w;
      logic [rv64sde_pkg::XLen-1:0]    pc;
      logic [rv64sde_pkg::RegIdxW-1:0] rd;
      logic [5:0]                      imm6;
      logic [20:0]                     jimm;
      logic                            ok;
      rv64sde_pkg::out_item_t          r;
      w         = x.instruction_word;
      pc        = x.pc;
      r         = '0;
      r.status  = rv64sde_pkg::StContinue;
      r.next_pc = pc;
      ok        = 1'b0;
      rd        = w[11:7];
      if (w[1:0] != rv64sde_pkg::QuadStd) begin
        imm6     = {w[12], w[6:2]};
        r.length = rv64sde_pkg::LenC;
        if (w[1:0] == rv64sde_pkg::QuadC1 && w[15:13] == rv64sde_pkg::F3CAddi &&
            rd != rv64sde_pkg::RegZero && imm6 != '0) begin
          r.reg_write_valid = 1'b1;
          r.reg_index       = rd;
          r.reg_value       = xregs[rd] + {{58{imm6[5]}}, imm6};
          ok                = 1'b1;
        end else if (w[1:0] == rv64sde_pkg::QuadC1 && w[15:13] == rv64sde_pkg::F3CLui &&
                     rd != rv64sde_pkg::RegZero && rd != rv64sde_pkg::RegSp &&
                     imm6 != '0) begin
          r.reg_write_valid = 1'b1;
          r.reg_index       = rd;
          r.reg_value       = {{46{imm6[5]}}, imm6, 12'b0};
          ok                = 1'b1;
        end else if (w[1:0] == rv64sde_pkg::QuadC2 && w[15:13] == rv64sde_pkg::F3CSdsp) begin
          // offset bits 5:3 from 12:10, bits 8:6 from 9:7
          r.store_valid   = 1'b1;
          r.store_address = xregs[rv64sde_pkg::RegSp] + {55'b0, w[9:7], w[12:10], 3'b0};
          r.store_data    = xregs[w[6:2]];
          ok              = 1'b1;
        end
        if (ok) r.next_pc = pc + 64'(rv64sde_pkg::LenC);
      end else begin
        r.length = rv64sde_pkg::LenStd;
        if (w[6:0] == rv64sde_pkg::OpcOpImm && w[14:12] == rv64sde_pkg::F3Addi &&
            rd != rv64sde_pkg::RegZero) begin
          r.reg_write_valid = 1'b1;
          r.reg_index       = rd;
          r.reg_value       = xregs[w[19:15]] + {{52{w[31]}}, w[31:20]};
          r.next_pc         = pc + 64'(rv64sde_pkg::LenStd);
          ok                = 1'b1;
        end else if (w[6:0] == rv64sde_pkg::OpcJal) begin
          jimm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
          if (rd != rv64sde_pkg::RegZero) begin
            r.reg_write_valid = 1'b1;
            r.reg_index       = rd;
            r.reg_value       = pc + 64'(rv64sde_pkg::LenStd);
          end
          r.next_pc = pc + {{43{jimm[20]}}, jimm};
          r.status  = rv64sde_pkg::StStop;
          ok        = 1'b1;
        end
      end
      if (!ok) begin
        r         = '0;
        r.status  = rv64sde_pkg::StNoDecode;
        r.length  = rv64sde_pkg::LenNone;
        r.next_pc = pc;
      end else if (r.reg_write_valid) begin
        xregs[r.reg_index] = r.reg_value;
      end
      return r;
    endfunction

    function void note_input(rv64sde_pkg::in_item_t x);
      expected_results.push_back(execute_instr(x));
    endfunction

    function bit field_ok(string fname, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, e, a);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(rv64sde_pkg::out_item_t got);
      rv64sde_pkg::out_item_t e;
      bit                     ok;
      if (expected_results.size() == 0) begin
        $display("%0t: result item with nothing expected: actual %h", $time, got);
        errors++;
        return;
      end
      e  = expected_results.pop_front();
      ok = field_ok("status", 64'(e.status), 64'(got.status)) &
           field_ok("length", 64'(e.length), 64'(got.length)) &
           field_ok("next_pc", e.next_pc, got.next_pc) &
           field_ok("reg_write_valid", 64'(e.reg_write_valid), 64'(got.reg_write_valid)) &
           field_ok("reg_index", 64'(e.reg_index), 64'(got.reg_index)) &
           field_ok("reg_value", e.reg_value, got.reg_value) &
           field_ok("store_valid", 64'(e.store_valid), 64'(got.store_valid)) &
           field_ok("store_address", e.store_address, got.store_address) &
           field_ok("store_data", e.store_data, got.store_data);
      if (!ok) errors++;
      n_checked++;
      if (e.reg_write_valid) n_writes++;
      if (e.store_valid) n_stores++;
      if (e.status == rv64sde_pkg::StStop) n_jumps++;
      if (e.status == rv64sde_pkg::StNoDecode) n_nodecode++;
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   out_ready_i = 1'b0;
  rv64sde_pkg::in_item_t  in_item_i   = '0;
  logic                   in_ready_o;
  logic                   out_valid_o;
  rv64sde_pkg::out_item_t out_item_o;

  exec_checker checker_h = new();

  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 1;
  int unsigned rx_phase    = 0;
  int unsigned rx_mode     = 0;

  rv64_subset_decode_execute dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // check results before noting inputs: a result never belongs to an item accepted this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) checker_h.check_result(out_item_o);
      if (in_valid_i && in_ready_o) checker_h.note_input(in_item_i);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // receiver: always ready, random stalls, or long stall runs, switching now and then
  always @(posedge clk_i) begin
    if (rx_phase == 0) begin
      rx_mode  <= $urandom_range(0, 2);
      rx_phase <= $urandom_range(20, 150);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if ($urandom_range(0, 5) == 0) out_ready_i <= ~out_ready_i;
      end
    endcase
  end

  task automatic send_instr(logic [31:0] w, logic [rv64sde_pkg::XLen-1:0] pc);
    rv64sde_pkg::in_item_t x;
    int unsigned           gap;
    x.instruction_word = w;
    x.pc               = pc;
    in_valid_i <= 1'b1;
    in_item_i  <= x;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [31:0] enc_c_addi(logic [4:0] rd, logic [5:0] imm);
    return {16'($urandom), rv64sde_pkg::F3CAddi, imm[5], rd, imm[4:0], rv64sde_pkg::QuadC1};
  endfunction

  function automatic logic [31:0] enc_c_lui(logic [4:0] rd, logic [5:0] imm);
    return {16'($urandom), rv64sde_pkg::F3CLui, imm[5], rd, imm[4:0], rv64sde_pkg::QuadC1};
  endfunction

  function automatic logic [31:0] enc_c_sdsp(logic [4:0] rs2, logic [2:0] off_lo,
                                              logic [2:0] off_hi);
    return {16'($urandom), rv64sde_pkg::F3CSdsp, off_lo, off_hi, rs2, rv64sde_pkg::QuadC2};
  endfunction

  function automatic logic [31:0] enc_addi(logic [4:0] rd, logic [4:0] rs, logic [11:0] imm);
    return {imm, rs, rv64sde_pkg::F3Addi, rd, rv64sde_pkg::OpcOpImm};
  endfunction

  function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv64sde_pkg::OpcJal};
  endfunction

  // mostly a few low registers so results feed the next instructions
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 2) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 5));
  endfunction

  function automatic logic [rv64sde_pkg::XLen-1:0] pick_pc();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 64'($urandom_range(0, 64));
    if (sel == 1) return '1 - 64'($urandom_range(0, 64));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] random_instr();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      w = enc_c_addi(pick_reg(), 6'($urandom));
    end else if (sel < 30) begin
      w = enc_c_lui(pick_reg(), 6'($urandom));
    end else if (sel < 45) begin
      w = enc_c_sdsp(pick_reg(), 3'($urandom), 3'($urandom));
    end else if (sel < 65) begin
      w = enc_addi(pick_reg(), pick_reg(), 12'($urandom));
    end else if (sel < 78) begin
      w = enc_jal(pick_reg(), 21'($urandom));
    end else if (sel < 86) begin
      w = $urandom;
    end else if (sel < 92) begin
      // compressed word of any quadrant and function
      w = {16'($urandom), 14'($urandom), 2'($urandom_range(0, 2))};
    end else begin
      // near miss: addi with one bit of funct3 or opcode flipped
      w = enc_addi(pick_reg(), pick_reg(), 12'($urandom));
      if ($urandom_range(0, 1) == 0) w[$urandom_range(12, 14)] ^= 1'b1;
      else w[$urandom_range(2, 6)] ^= 1'b1;
    end
    return w;
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: immediate extremes, invalid forms, wraparound of pc
    send_instr(enc_c_addi(5'd1, 6'h1f), 64'h0);
    send_instr(enc_c_addi(5'd1, 6'h20), 64'h2);
    send_instr(enc_c_addi(5'd1, 6'h00), 64'h4);
    send_instr(enc_c_addi(5'd0, 6'h05), 64'h6);
    send_instr(enc_c_lui(5'd3, 6'h1f), 64'h8);
    send_instr(enc_c_lui(5'd4, 6'h20), 64'ha);
    send_instr(enc_c_lui(rv64sde_pkg::RegSp, 6'h01), 64'hc);
    send_instr(enc_c_lui(5'd0, 6'h01), 64'he);
    send_instr(enc_c_lui(5'd5, 6'h00), 64'h10);
    send_instr(enc_addi(rv64sde_pkg::RegSp, 5'd0, 12'h7ff), 64'h12);
    send_instr(enc_addi(5'd5, 5'd4, 12'h800), 64'h16);
    send_instr(enc_addi(5'd0, 5'd1, 12'h001), 64'h1a);
    send_instr(enc_addi(5'd31, 5'd31, 12'hfff), 64'h1e);
    send_instr(enc_addi(5'd6, 5'd2, 12'h001) | 32'h0000_1000, 64'h22);
    send_instr(enc_c_sdsp(5'd31, 3'd7, 3'd7), 64'h26);
    send_instr(enc_c_sdsp(5'd0, 3'd0, 3'd0), 64'h28);
    send_instr(enc_jal(5'd1, 21'h0ffffe), 64'hffff_ffff_fff0_0000);
    send_instr(enc_jal(5'd0, 21'h100000), 64'h40);
    send_instr(enc_jal(5'd31, 21'h000000), 64'h8000_0000_0000_0000);
    send_instr(32'h0000_0000, 64'h100);
    send_instr(32'hffff_ffff, 64'h104);
    send_instr(enc_c_addi(5'd7, 6'h11) | 32'hffff_0000, 64'h108);
    send_instr(enc_addi(5'd8, 5'd1, 12'h123), 64'hffff_ffff_ffff_ffff);
    send_instr(enc_c_sdsp(5'd8, 3'd5, 3'd2), 64'hffff_ffff_ffff_fffe);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      send_instr(random_instr(), pick_pc());
    end
    in_valid_i <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk_i);

    while (checker_h.expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("checked %0d result items under random sender gaps and receiver stalls",
             checker_h.n_checked);
    $display("register writes %0d, stores %0d, jumps %0d, not decoded %0d",
             checker_h.n_writes, checker_h.n_stores, checker_h.n_jumps, checker_h.n_nodecode);
    if (checker_h.errors == 0 && checker_h.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
